>>> hdl/ptpps_pkg.sv
package ptpps_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;

  // Field widths
  localparam int START_W  = 3;
  localparam int CNT_W    = 11;
  localparam int PLANES   = 4;
  localparam int PIX_W    = 4;
  localparam int PAD_W    = 2;
  localparam int BYTE_W   = 8;

  // Rightmost pixel position within a screen byte
  localparam logic [START_W-1:0] LAST_POS = 3'd7;

  // Reset values of the registers
  localparam logic [START_W-1:0] START_BIT_RST = 3'd0;
  localparam logic [CNT_W-1:0]   ROW_WIDTH_RST = 11'd1;

  typedef logic [PLANES-1:0][BYTE_W-1:0] planes_t;

endpackage

>>> hdl/ptpps_in_if.sv
interface ptpps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane0_byte;
  logic [7:0] plane1_byte;
  logic [7:0] plane2_byte;
  logic [7:0] plane3_byte;

  modport source (
    output valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
    input  ready
  );
  modport sink (
    input  valid, plane0_byte, plane1_byte, plane2_byte, plane3_byte,
    output ready
  );
endinterface

>>> hdl/ptpps_out_if.sv
interface ptpps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_value;
  logic       row_end;
  logic [1:0] pad_after;
  logic       item_end;

  modport source (
    output valid, pixel_value, row_end, pad_after, item_end,
    input  ready
  );
  modport sink (
    input  valid, pixel_value, row_end, pad_after, item_end,
    output ready
  );
endinterface

>>> hdl/planar_to_packed_pixel_span_unit.sv
// Planar to packed pixel converter for one screen row span. Each request
// carries the four plane bytes of one screen byte column (eight pixels, bit 7
// leftmost); the unit issues one 4-bit packed pixel per cycle, plane p on
// pixel bit p, while the output is not stalled. A request therefore yields
// 8 - start_bit pixels on the first byte of a row, 8 on the others, and fewer
// on the byte that closes the row. The next request is taken in the same
// cycle that the last pixel of the current one is issued, so back-to-back
// requests leave no gap on the output. start_bit is sampled when a row's first
// byte issues its first pixel; row_width of zero acts as one and is capped at
// MAX_ROW_WIDTH. The last pixel of a row carries row_end and
// pad_after = (-width) mod 4. There is no clearing pass after reset.
module planar_to_packed_pixel_span_unit #(
  parameter int MAX_ROW_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptpps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptpps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ptpps_in_if.sink                       in_i,
  ptpps_out_if.source                    out_o
);
  import ptpps_pkg::*;

  // Configuration registers
  logic [START_W-1:0] start_bit_q;
  logic [CNT_W-1:0]   row_width_q;

  // Item register
  logic               item_valid_q, item_valid_d;
  logic               fresh_q, fresh_d;
  logic [START_W-1:0] pos_q, pos_d;
  planes_t            planes_q;

  // Row state
  logic [CNT_W-1:0]   pixels_done_q, pixels_done_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   pix_q;
  logic               row_end_q;
  logic [PAD_W-1:0]   pad_q;
  logic               item_end_q;

  logic               produce, item_free, load;
  logic [START_W-1:0] cur_pos, bit_sel;
  logic [PIX_W-1:0]   pix;
  logic [CNT_W-1:0]   eff_w, done_inc;
  logic               last_row, last_item;
  logic [PAD_W-1:0]   pad;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bit_q <= START_BIT_RST;
      row_width_q <= ROW_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_BIT: start_bit_q <= cfg_data_i[START_W-1:0];
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row width: zero acts as one, capped at the maximum
  always_comb begin
    eff_w = row_width_q;
    if (row_width_q == '0) begin
      eff_w = CNT_W'(1);
    end else if (int'(row_width_q) > MAX_ROW_WIDTH) begin
      eff_w = CNT_W'(MAX_ROW_WIDTH);
    end
  end

  // Pixel issue for the current position
  assign produce  = item_valid_q && (!out_valid_q || out_o.ready);
  assign cur_pos  = fresh_q ? ((pixels_done_q == '0) ? start_bit_q : '0) : pos_q;
  assign bit_sel  = LAST_POS - cur_pos;

  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      pix[p] = planes_q[p][bit_sel];
    end
  end

  assign done_inc  = pixels_done_q + CNT_W'(1);
  assign last_row  = (done_inc >= eff_w);
  assign last_item = last_row || (cur_pos == LAST_POS);
  assign pad       = PAD_W'(2'd0 - eff_w[PAD_W-1:0]);

  // Next item may enter as the last pixel of the current one issues
  assign item_free  = !item_valid_q || (produce && last_item);
  assign load       = in_i.valid && item_free;
  assign in_i.ready = item_free;

  always_comb begin
    item_valid_d  = item_valid_q;
    fresh_d       = fresh_q;
    pos_d         = pos_q;
    pixels_done_d = pixels_done_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    if (produce) begin
      out_valid_d   = 1'b1;
      pos_d         = cur_pos + START_W'(1);
      fresh_d       = 1'b0;
      pixels_done_d = last_row ? '0 : done_inc;
      if (last_item) begin
        item_valid_d = 1'b0;
      end
    end
    if (load) begin
      item_valid_d = 1'b1;
      fresh_d      = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q  <= 1'b0;
      fresh_q       <= 1'b0;
      pos_q         <= '0;
      pixels_done_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      item_valid_q  <= item_valid_d;
      fresh_q       <= fresh_d;
      pos_q         <= pos_d;
      pixels_done_q <= pixels_done_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (load) begin
      planes_q <= {in_i.plane3_byte, in_i.plane2_byte, in_i.plane1_byte, in_i.plane0_byte};
    end
    if (produce) begin
      pix_q      <= pix;
      row_end_q  <= last_row;
      pad_q      <= last_row ? pad : '0;
      item_end_q <= last_item;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_value = pix_q;
  assign out_o.row_end     = row_end_q;
  assign out_o.pad_after   = pad_q;
  assign out_o.item_end    = item_end_q;

endmodule

>>> hdl/ptpps_checker.sv
module ptpps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ptpps_pkg::PIX_W-1:0]   pixel_value_i,
  input logic                          row_end_i,
  input logic [ptpps_pkg::PAD_W-1:0]   pad_after_i,
  input logic                          item_end_i
);
  import ptpps_pkg::*;

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pixel_value_i))
    else $error("pixel changed while stalled");

  // The row's last pixel also closes its byte column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && row_end_i |-> item_end_i)
    else $error("row end without item end");

  // Padding only shows on the row's last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (pad_after_i != '0) |-> row_end_i)
    else $error("pad count outside row end");

endmodule

bind planar_to_packed_pixel_span_unit ptpps_checker u_ptpps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_value_i (out_o.pixel_value),
  .row_end_i     (out_o.row_end),
  .pad_after_i   (out_o.pad_after),
  .item_end_i    (out_o.item_end)
);
